FILE: design/lbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared types, constants and helpers for the lattice bond force pipeline.
// ----------------------------------------------------------------------------
package lbf_pkg;

	localparam int SQ_STAGES  = 32;  // one root bit per stage
	localparam int DIV_STAGES = 33;  // one quotient bit per stage
	// s1..s3, root line, s4..s8, divider with entry register, output register
	localparam int LATENCY    = 3 + (SQ_STAGES + 1) + 5 + (DIV_STAGES + 1) + 1;

	localparam logic [2:0] REG_STIFF1  = 3'd0;
	localparam logic [2:0] REG_STIFF2  = 3'd1;
	localparam logic [2:0] REG_STIFF3  = 3'd2;
	localparam logic [2:0] REG_NL1     = 3'd3;
	localparam logic [2:0] REG_NL23    = 3'd4;
	localparam logic [2:0] REG_REST1   = 3'd5;
	localparam logic [2:0] REG_REST2   = 3'd6;
	localparam logic [2:0] REG_REST3   = 3'd7;

	localparam logic [1:0] SHELL_FIRST  = 2'd0;
	localparam logic [1:0] SHELL_SECOND = 2'd1;
	localparam logic [1:0] SHELL_THIRD  = 2'd2;

	localparam logic [31:0] MAX32 = 32'h7fff_ffff;
	localparam logic [31:0] MIN32 = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] stiff;
		logic [30:0] rest;
		logic [31:0] tk;
		logic [2:0]  neg_d;
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] mz;
		logic        want;
		logic        sat;
	} side_t;

	typedef struct packed {
		logic        neg_s;
		logic [2:0]  neg_d;
		logic        zero;
		logic        want;
		logic        sat;
		logic [31:0] en;
	} dside_t;

	// clip to 32-bit signed, flag in the top bit
	function automatic logic [32:0] sat64(input logic signed [63:0] v);
		logic hi;
		logic lo;
		hi = v > $signed({32'd0, MAX32});
		lo = v < $signed({32'hffff_ffff, MIN32});
		if (hi)
			return {1'b1, MAX32};
		else if (lo)
			return {1'b1, MIN32};
		else
			return {1'b0, v[31:0]};
	endfunction

endpackage

FILE: design/lbf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbf_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module lbf_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] val,
	output logic [31:0] root
);

	localparam int N = lbf_pkg::SQ_STAGES;

	logic [63:0] v_st    [0:N];
	logic [34:0] rem_st  [0:N];
	logic [31:0] root_st [0:N];

	always_ff @(posedge clk) begin
		if (en) begin
			v_st[0]    <= val;
			rem_st[0]  <= '0;
			root_st[0] <= '0;
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_stage
		logic [34:0] t;
		logic [34:0] trial;
		logic        ge;
		assign t     = {rem_st[i-1][32:0], v_st[i-1][63:62]};
		assign trial = {1'b0, root_st[i-1], 2'b01};
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				v_st[i]    <= {v_st[i-1][61:0], 2'b00};
				rem_st[i]  <= ge ? (t - trial) : t;
				root_st[i] <= {root_st[i-1][30:0], ge};
			end
		end
	end

	assign root = root_st[N];

endmodule

FILE: design/lbf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbf_div
// Pipelined 64 by 32 unsigned divider giving a 33-bit quotient and overflow.
// ----------------------------------------------------------------------------
module lbf_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [32:0] quo,
	output logic        ovf
);

	localparam int N = lbf_pkg::DIV_STAGES;

	logic [31:0] rem_st [0:N];
	logic [32:0] low_st [0:N];
	logic [32:0] q_st   [0:N];
	logic [31:0] den_st [0:N];
	logic        ovf_st [0:N];

	// quotient of 2^33 or more shows as soon as the top bits reach the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_st[0] <= {1'b0, num[63:33]};
			low_st[0] <= num[32:0];
			q_st[0]   <= '0;
			den_st[0] <= den;
			ovf_st[0] <= {1'b0, num[63:33]} >= den;
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_stage
		logic [32:0] t;
		logic [32:0] diff;
		logic        ge;
		assign t    = {rem_st[i-1], low_st[i-1][32]};
		assign diff = t - {1'b0, den_st[i-1]};
		assign ge   = t >= {1'b0, den_st[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[i] <= ge ? diff[31:0] : t[31:0];
				low_st[i] <= {low_st[i-1][31:0], 1'b0};
				q_st[i]   <= {q_st[i-1][31:0], ge};
				den_st[i] <= den_st[i-1];
				ovf_st[i] <= ovf_st[i-1];
			end
		end
	end

	assign quo = q_st[N];
	assign ovf = ovf_st[N];

endmodule

FILE: design/lattice_bond_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_bond_force
// Spring force, stretch and energy of one lattice bond per transfer.
// ----------------------------------------------------------------------------
// Usage:
//  s_* carries one bond per transfer: tdata holds disp_x, disp_y, disp_z and
//  stretch_sum (32 bits each, from bit 0 up); tuser holds shell and
//  want_energy. m_* returns one result per bond in the same order: tdata holds
//  force_x, force_y, force_z and bond_energy, tuser zero_length and saturated.
//  cfg_* writes the eight coefficient registers; cfg_ready is always high.
//  Write them only while no bond is in flight.
//  The pipeline takes one bond per cycle while the output is not stalled.
//  Depth is set by the 32-stage square root and the 33-stage divider, each
//  resolving one bit per stage.
//  The whole pipeline moves as one: when the output register holds a result
//  the receiver has not taken, every stage holds and s_tready drops, so
//  nothing is lost or repeated. Reset empties the pipeline and clears the
//  registers to zero.
// ----------------------------------------------------------------------------
module lattice_bond_force (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // disp_x, disp_y, disp_z, stretch_sum
	input  logic [2:0]   s_tuser,   // shell, want_energy
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // force_x, force_y, force_z, bond_energy
	output logic [1:0]   m_tuser,   // zero_length, saturated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int LAT = lbf_pkg::LATENCY;
	localparam int SQN = lbf_pkg::SQ_STAGES;
	localparam int DVN = lbf_pkg::DIV_STAGES;

	logic        adv;
	logic        vch [0:LAT-1];

	logic [31:0] stiff1_q, stiff2_q, stiff3_q, nl1_q, nl23_q;
	logic [30:0] rest1_q, rest2_q, rest3_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff1_q <= '0;
			stiff2_q <= '0;
			stiff3_q <= '0;
			nl1_q    <= '0;
			nl23_q   <= '0;
			rest1_q  <= '0;
			rest2_q  <= '0;
			rest3_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lbf_pkg::REG_STIFF1: stiff1_q <= cfg_data;
				lbf_pkg::REG_STIFF2: stiff2_q <= cfg_data;
				lbf_pkg::REG_STIFF3: stiff3_q <= cfg_data;
				lbf_pkg::REG_NL1:    nl1_q    <= cfg_data;
				lbf_pkg::REG_NL23:   nl23_q   <= cfg_data;
				lbf_pkg::REG_REST1:  rest1_q  <= cfg_data[30:0];
				lbf_pkg::REG_REST2:  rest2_q  <= cfg_data[30:0];
				lbf_pkg::REG_REST3:  rest3_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vch[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				vch[i] <= 1'b0;
		end else if (adv) begin
			vch[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++)
				vch[i] <= vch[i-1];
		end
	end

	// ---------------- s1: operand select ----------------
	logic signed [31:0] dx, dy, dz, ssum;
	logic [1:0]  sh;
	lbf_pkg::side_t side_in, side_s1, side_s2, side_s3;
	logic [31:0] nl_sel, nl_s1, ssum_s1;

	assign dx   = s_tdata[31:0];
	assign dy   = s_tdata[63:32];
	assign dz   = s_tdata[95:64];
	assign ssum = s_tdata[127:96];
	// shell code three behaves as the third shell
	assign sh   = (s_tuser[1:0] > lbf_pkg::SHELL_THIRD) ? lbf_pkg::SHELL_THIRD : s_tuser[1:0];

	always_comb begin
		side_in       = '0;
		side_in.neg_d = {dz[31], dy[31], dx[31]};
		side_in.mx    = dx[31] ? (32'd0 - dx) : dx;
		side_in.my    = dy[31] ? (32'd0 - dy) : dy;
		side_in.mz    = dz[31] ? (32'd0 - dz) : dz;
		side_in.want  = s_tuser[2];
		case (sh)
			lbf_pkg::SHELL_FIRST: begin
				side_in.stiff = stiff1_q;
				side_in.rest  = rest1_q;
			end
			lbf_pkg::SHELL_SECOND: begin
				side_in.stiff = stiff2_q;
				side_in.rest  = rest2_q;
			end
			default: begin
				side_in.stiff = stiff3_q;
				side_in.rest  = rest3_q;
			end
		endcase
		nl_sel = (sh == lbf_pkg::SHELL_FIRST) ? nl1_q : nl23_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			nl_s1   <= nl_sel;
			ssum_s1 <= ssum;
		end
	end

	// ---------------- s2: squares and nonlocal product ----------------
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;
	logic signed [63:0] tkp_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= 64'(side_s1.mx) * 64'(side_s1.mx);
			sqy_s2  <= 64'(side_s1.my) * 64'(side_s1.my);
			sqz_s2  <= 64'(side_s1.mz) * 64'(side_s1.mz);
			tkp_s2  <= 64'($signed(nl_s1)) * 64'($signed(ssum_s1));
			side_s2 <= side_s1;
		end
	end

	// ---------------- s3: sum of squares, tangential term ----------------
	logic [63:0] sq_s3;
	logic [32:0] tk_sat;
	lbf_pkg::side_t side_n3;

	assign tk_sat = lbf_pkg::sat64(tkp_s2 >>> 18);

	always_comb begin
		side_n3     = side_s2;
		side_n3.tk  = tk_sat[31:0];
		side_n3.sat = side_s2.sat | tk_sat[32];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3   <= sqx_s2 + sqy_s2 + sqz_s2;
			side_s3 <= side_n3;
		end
	end

	// ---------------- bond length ----------------
	logic [31:0] root;
	lbf_pkg::side_t side_line [0:SQN];

	lbf_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  (sq_s3),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_line[0] <= side_s3;
			for (int i = 1; i <= SQN; i++)
				side_line[i] <= side_line[i-1];
		end
	end

	// ---------------- s4: stretch ----------------
	logic [32:0] dr_sat;
	logic [31:0] r_s4, r_s5, r_s6, r_s7, r_s8;
	logic [31:0] dr_s4, dr_s5, dr_s6, dr_s7;
	lbf_pkg::side_t side_s4, side_s5, side_s6, side_s7, side_s8;
	lbf_pkg::side_t side_n4;

	assign dr_sat = lbf_pkg::sat64($signed({32'd0, root}) - $signed({33'd0, side_line[SQN].rest}));

	always_comb begin
		side_n4     = side_line[SQN];
		side_n4.sat = side_line[SQN].sat | dr_sat[32];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s4    <= root;
			dr_s4   <= dr_sat[31:0];
			side_s4 <= side_n4;
		end
	end

	// ---------------- s5: normal product ----------------
	logic signed [63:0] rkp_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			rkp_s5  <= 64'($signed(side_s4.stiff)) * 64'($signed(dr_s4));
			r_s5    <= r_s4;
			dr_s5   <= dr_s4;
			side_s5 <= side_s4;
		end
	end

	// ---------------- s6: normal term ----------------
	logic [32:0] rk_sat;
	logic [31:0] rk_s6;
	lbf_pkg::side_t side_n6;

	assign rk_sat = lbf_pkg::sat64(rkp_s5 >>> 17);

	always_comb begin
		side_n6     = side_s5;
		side_n6.sat = side_s5.sat | rk_sat[32];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rk_s6   <= rk_sat[31:0];
			r_s6    <= r_s5;
			dr_s6   <= dr_s5;
			side_s6 <= side_n6;
		end
	end

	// ---------------- s7: pair sum ----------------
	logic [32:0] s_sat;
	logic [31:0] s_s7;
	lbf_pkg::side_t side_n7;

	assign s_sat = lbf_pkg::sat64(64'($signed(rk_s6)) + 64'($signed(side_s6.tk)));

	always_comb begin
		side_n7     = side_s6;
		side_n7.sat = side_s6.sat | s_sat[32];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s7    <= s_sat[31:0];
			r_s7    <= r_s6;
			dr_s7   <= dr_s6;
			side_s7 <= side_n7;
		end
	end

	// ---------------- s8: force and energy products ----------------
	logic [31:0] ms;
	logic [63:0] px_s8, py_s8, pz_s8;
	logic signed [63:0] pe_s8;
	logic        neg_s_s8;

	assign ms = s_s7[31] ? (32'd0 - s_s7) : s_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s8    <= 64'(ms) * 64'(side_s7.mx);
			py_s8    <= 64'(ms) * 64'(side_s7.my);
			pz_s8    <= 64'(ms) * 64'(side_s7.mz);
			pe_s8    <= 64'($signed(s_s7)) * 64'($signed(dr_s7));
			neg_s_s8 <= s_s7[31];
			r_s8     <= r_s7;
			side_s8  <= side_s7;
		end
	end

	// ---------------- divide by length ----------------
	logic [32:0] en_sat;
	lbf_pkg::dside_t dside_in;
	lbf_pkg::dside_t dline [0:DVN];
	logic [32:0] qx, qy, qz;
	logic        ox, oy, oz;

	assign en_sat = lbf_pkg::sat64(pe_s8 >>> 17);

	always_comb begin
		dside_in       = '0;
		dside_in.neg_s = neg_s_s8;
		dside_in.neg_d = side_s8.neg_d;
		dside_in.zero  = r_s8 == 32'd0;
		dside_in.want  = side_s8.want;
		// clipping of the energy only counts when it was asked for
		dside_in.sat   = side_s8.sat | (side_s8.want & en_sat[32]);
		dside_in.en    = side_s8.want ? en_sat[31:0] : 32'd0;
	end

	lbf_div u_div_x (.clk(clk), .en(adv), .num(px_s8), .den(r_s8), .quo(qx), .ovf(ox));
	lbf_div u_div_y (.clk(clk), .en(adv), .num(py_s8), .den(r_s8), .quo(qy), .ovf(oy));
	lbf_div u_div_z (.clk(clk), .en(adv), .num(pz_s8), .den(r_s8), .quo(qz), .ovf(oz));

	always_ff @(posedge clk) begin
		if (adv) begin
			dline[0] <= dside_in;
			for (int i = 1; i <= DVN; i++)
				dline[i] <= dline[i-1];
		end
	end

	// ---------------- output stage ----------------
	// force is negative when s and d share a sign
	function automatic logic [32:0] fsel(input logic neg, input logic ovf, input logic [32:0] q);
		if (neg) begin
			if (ovf || q > 33'h0_8000_0000)
				return {1'b1, lbf_pkg::MIN32};
			else
				return {1'b0, 32'd0 - q[31:0]};
		end else begin
			if (ovf || q > 33'h0_7fff_ffff)
				return {1'b1, lbf_pkg::MAX32};
			else
				return {1'b0, q[31:0]};
		end
	endfunction

	lbf_pkg::dside_t dfin;
	logic [32:0] fx, fy, fz;
	logic [127:0] tdata_q;
	logic [1:0]   tuser_q;
	logic         want_q;

	assign dfin = dline[DVN];
	assign fx   = dfin.zero ? 33'd0 : fsel(dfin.neg_s == dfin.neg_d[0], ox, qx);
	assign fy   = dfin.zero ? 33'd0 : fsel(dfin.neg_s == dfin.neg_d[1], oy, qy);
	assign fz   = dfin.zero ? 33'd0 : fsel(dfin.neg_s == dfin.neg_d[2], oz, qz);

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_q <= {dfin.en, fz[31:0], fy[31:0], fx[31:0]};
			tuser_q <= {dfin.sat | fx[32] | fy[32] | fz[32], dfin.zero};
			want_q  <= dfin.want;
		end
	end

	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

	// ---------------- assertions ----------------
	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[95:0] == 96'd0)
		else $error("zero length bond with nonzero force");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output stall");

	a_energy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !want_q |-> m_tdata[127:96] == 32'd0)
		else $error("energy given without request");

endmodule
